// ----- design/rau_pkg.sv -----
package rau_pkg;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_NEG  = 3'd4,
		OP_INV  = 3'd5,
		OP_NORM = 3'd6,
		OP_EQ   = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	// intermediate magnitudes
	localparam int MAG_W = 64;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DEC,
		S_G1_START,
		S_G1_WAIT,
		S_ADD_SCALE,
		S_ADD_M1,
		S_ADD_M2,
		S_ADD_M3,
		S_ADD_SUM,
		S_MUL_G2_START,
		S_MUL_G2_WAIT,
		S_MUL_DIV,
		S_MUL_M1,
		S_MUL_M2,
		S_DIV_M1,
		S_DIV_M2,
		S_RED_START,
		S_RED_GCD_WAIT,
		S_RED_DIV,
		S_RED_CHECK,
		S_OUT
	} state_t;

	// request to the shared divider (quotient and remainder)
	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] dividend;
		logic [MAG_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [MAG_W-1:0] quot;
		logic [MAG_W-1:0] rem;
	} div_rsp_t;

endpackage

// ----- design/rau_divider.sv -----
module rau_divider
	import rau_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic [MAG_W-1:0] quot_q;
	logic [MAG_W:0]   rem_q;
	logic [MAG_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [MAG_W:0]   shifted;
	logic [MAG_W:0]   diff;

	// restoring division, one quotient bit per cycle
	always_comb begin
		shifted = {rem_q[MAG_W-1:0], quot_q[MAG_W-1]};
		diff    = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			if (!diff[MAG_W]) begin
				rem_q  <= diff;
				quot_q <= {quot_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q  <= shifted;
				quot_q <= {quot_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q[MAG_W-1:0];

endmodule

// ----- design/rau_gcd.sv -----
module rau_gcd
	import rau_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] x,
	input  logic [MAG_W-1:0] y,
	input  div_rsp_t         div_rsp,
	output div_req_t         div_req,
	output logic             done,
	output logic [MAG_W-1:0] result
);

	logic [MAG_W-1:0] x_q;
	logic [MAG_W-1:0] y_q;
	logic             run_q;
	logic             wait_q;
	logic             done_q;

	// Euclid: one remainder per divider run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			wait_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				wait_q <= 1'b0;
			end else if (run_q && !wait_q) begin
				if (y_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					wait_q <= 1'b1;
				end
			end else if (run_q && div_rsp.done) begin
				wait_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			y_q <= y;
		end else if (run_q && wait_q && div_rsp.done) begin
			x_q <= y_q;
			y_q <= div_rsp.rem;
		end
	end

	always_comb begin
		div_req.start    = run_q && !wait_q && !start && (y_q != '0);
		div_req.dividend = x_q;
		div_req.divisor  = y_q;
	end

	assign done   = done_q;
	assign result = x_q;

endmodule

// ----- design/rational_arithmetic_unit.sv -----
// Rational arithmetic unit: one operation on two fractions per beat.
// For negate, invert and equal the input beat passes through S_DEC and the
// result beat is then offered in S_OUT; a new input beat is taken in S_IDLE.
// add/sub/mul/div/normalize run up to three Euclid gcds and several divisions
// on one shared 64-bit restoring divider. Throughput: one beat at a time;
// in_stall is high from acceptance until the result beat is taken. Reset
// (arst_n low) clears control state only.
module rational_arithmetic_unit
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [2:0]                      operation,
	input  logic signed [OPERAND_WIDTH-1:0] a_num,
	input  logic signed [OPERAND_WIDTH-1:0] a_den,
	input  logic signed [OPERAND_WIDTH-1:0] b_num,
	input  logic signed [OPERAND_WIDTH-1:0] b_den,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [OPERAND_WIDTH-1:0] res_num,
	output logic signed [OPERAND_WIDTH-1:0] res_den,
	output logic                            is_equal,
	output logic [1:0]                      status
);

	localparam int W = OPERAND_WIDTH;
	localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (W - 1);

	state_t state_q, state_d;

	// captured operands
	op_t          op_q;
	logic [W-1:0] an_raw_q, ad_raw_q, bn_raw_q, bd_raw_q;

	// sign / magnitude working registers
	logic             an_s_q, ad_s_q, bn_s_q, bd_s_q;
	logic [MAG_W-1:0] an_m_q, ad_m_q, bn_m_q, bd_m_q;
	logic             n_s_q, d_s_q;
	logic [MAG_W-1:0] n_m_q, d_m_q;
	logic [MAG_W-1:0] g_q;
	logic             big_q;
	logic             t_s_q;
	logic [MAG_W-1:0] t_m_q;
	logic [1:0]       sub_q;

	// result register
	logic [W-1:0] rn_q, rd_q;
	logic         eq_q;
	status_t      st_q;

	// shared units
	div_req_t div_req, gcd_div_req, seq_div_req;
	div_rsp_t div_rsp;
	logic             gcd_start, gcd_done;
	logic [MAG_W-1:0] gcd_x, gcd_y, gcd_res;

	rau_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	rau_gcd u_gcd (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (gcd_start),
		.x       (gcd_x),
		.y       (gcd_y),
		.div_rsp (div_rsp),
		.div_req (gcd_div_req),
		.done    (gcd_done),
		.result  (gcd_res)
	);

	assign div_req = gcd_div_req.start ? gcd_div_req : seq_div_req;

	// decode one field into sign and magnitude
	function automatic logic [MAG_W:0] dec(input logic [W-1:0] raw);
		logic [MAG_W-1:0] v;
		logic [MAG_W-1:0] m;
		logic [W-1:0]     neg_raw;
		begin
			v = MAG_W'(raw);
			if (raw[W-1]) begin
				// negate at operand width; most negative gives HALF
				neg_raw = -raw;
				m = MAG_W'(neg_raw);
				dec = {1'b1, m};
			end else begin
				dec = {1'b0, v};
			end
		end
	endfunction

	function automatic logic [W-1:0] enc(input logic s, input logic [MAG_W-1:0] m);
		enc = s ? W'(-m) : W'(m);
	endfunction

	function automatic logic fits(input logic s, input logic [MAG_W-1:0] m);
		fits = s ? (m <= HALF) : (m <= HALF - 1);
	endfunction

	// 64x64 multiply in three 32x32 partial products; hi*hi flags overflow
	logic [31:0]      ma_h, ma_l, mb_h, mb_l;
	logic [MAG_W:0]   acc_q;
	logic             ovf_pp;
	logic [MAG_W-1:0] mul_a, mul_b;
	logic [MAG_W-1:0] pp;
	logic [1:0]       mstep_q;
	logic             mbig_q;

	assign ma_h = mul_a[63:32];
	assign ma_l = mul_a[31:0];
	assign mb_h = mul_b[63:32];
	assign mb_l = mul_b[31:0];

	always_comb begin
		case (mstep_q)
			2'd0:    pp = ma_l * mb_l;
			2'd1:    pp = ma_l * mb_h;
			2'd2:    pp = ma_h * mb_l;
			default: pp = '0;
		endcase
		ovf_pp = (ma_h != '0) && (mb_h != '0);
	end

	// multiplier operand select by state
	// add: t holds l = ad/g, g holds r = bd/g
	always_comb begin
		mul_a = an_m_q;
		mul_b = bd_m_q;
		case (state_q)
			S_ADD_M1: begin mul_a = an_m_q; mul_b = g_q;    end
			S_ADD_M2: begin mul_a = bn_m_q; mul_b = t_m_q;  end
			S_ADD_M3: begin mul_a = ad_m_q; mul_b = g_q;    end
			S_MUL_M1: begin mul_a = an_m_q; mul_b = bn_m_q; end
			S_MUL_M2: begin mul_a = ad_m_q; mul_b = bd_m_q; end
			S_DIV_M1: begin mul_a = an_m_q; mul_b = bd_m_q; end
			S_DIV_M2: begin mul_a = ad_m_q; mul_b = bn_m_q; end
			default: ;
		endcase
	end

	// product complete once mstep reaches 3; then sum is in acc_q
	logic [MAG_W:0] acc_nx;
	logic           prod_big;
	always_comb begin
		case (mstep_q)
			2'd0:    acc_nx = {1'b0, pp};
			2'd1:    acc_nx = acc_q + {1'b0, pp[31:0], 32'd0};
			2'd2:    acc_nx = acc_q + {1'b0, pp[31:0], 32'd0};
			default: acc_nx = acc_q;
		endcase
	end
	assign prod_big = mbig_q || acc_q[MAG_W];
	logic mul_busy;
	assign mul_busy = (mstep_q != 2'd3);

	// sequencer next state
	logic [MAG_W:0] sum_m;
	logic           sum_s;
	logic           sum_big;
	logic           eq_hit;

	always_comb begin
		logic [MAG_W:0] a1, b1;
		a1 = {1'b0, n_m_q};
		b1 = {1'b0, t_m_q};
		sum_big = 1'b0;
		if (n_s_q == t_s_q) begin
			sum_m   = a1 + b1;
			sum_s   = n_s_q;
			sum_big = sum_m[MAG_W];
		end else if (n_m_q >= t_m_q) begin
			sum_m = a1 - b1;
			sum_s = n_s_q;
		end else begin
			sum_m = b1 - a1;
			sum_s = t_s_q;
		end
		eq_hit = (an_raw_q == bn_raw_q) && (ad_raw_q == bd_raw_q);
	end

	always_comb begin
		state_d         = state_q;
		gcd_start       = 1'b0;
		gcd_x           = ad_m_q;
		gcd_y           = bd_m_q;
		seq_div_req     = '0;
		case (state_q)
			S_IDLE:         if (in_valid) state_d = S_DEC;
			S_DEC: begin
				// working registers load at this edge, so decide on the raw fields
				case (op_q)
					OP_ADD, OP_SUB: state_d = (ad_raw_q == '0 || bd_raw_q == '0) ? S_OUT :
						(ad_raw_q == bd_raw_q) ? S_ADD_SUM : S_G1_START;
					OP_MUL: state_d = (ad_raw_q == '0 || bd_raw_q == '0) ? S_OUT : S_G1_START;
					OP_DIV: state_d = (ad_raw_q == '0 || bd_raw_q == '0 || bn_raw_q == '0) ?
						S_OUT : S_DIV_M1;
					OP_NORM: state_d = (ad_raw_q == '0) ? S_OUT : S_RED_START;
					default: state_d = S_OUT;
				endcase
			end
			S_G1_START: begin
				gcd_start = 1'b1;
				if (op_q == OP_MUL) begin
					gcd_x = an_m_q;
					gcd_y = bd_m_q;
				end
				state_d = S_G1_WAIT;
			end
			S_G1_WAIT: if (gcd_done) state_d = (op_q == OP_MUL) ? S_MUL_DIV : S_ADD_SCALE;
			S_ADD_SCALE: begin
				// two divisions: ad/g -> t (l), bd/g -> g (r)
				if (sub_q == 2'd0 || (div_rsp.done && sub_q == 2'd1)) begin
					seq_div_req.start    = (g_q != '0);
					seq_div_req.dividend = (sub_q == 2'd0) ? ad_m_q : bd_m_q;
					seq_div_req.divisor  = g_q;
				end
				if (g_q == '0 || (div_rsp.done && sub_q == 2'd2)) state_d = S_ADD_M1;
			end
			S_ADD_M1: if (!mul_busy) state_d = S_ADD_M2;
			S_ADD_M2: if (!mul_busy) state_d = S_ADD_M3;
			S_ADD_M3: if (!mul_busy) state_d = S_RED_START;
			S_ADD_SUM: state_d = S_RED_START;
			S_MUL_DIV: begin
				// first pass divides an, bd by gcd(an,bd); second (t_s set) ad, bn
				if (g_q != '0 && (sub_q == 2'd0 || (div_rsp.done && sub_q == 2'd1))) begin
					seq_div_req.start    = 1'b1;
					seq_div_req.dividend = (sub_q == 2'd0) ? (t_s_q ? ad_m_q : an_m_q) :
						(t_s_q ? bn_m_q : bd_m_q);
					seq_div_req.divisor  = g_q;
				end
				if (g_q == '0 || (div_rsp.done && sub_q == 2'd2))
					state_d = t_s_q ? S_MUL_M1 : S_MUL_G2_START;
			end
			S_MUL_G2_START: begin
				gcd_start = 1'b1;
				gcd_x     = ad_m_q;
				gcd_y     = bn_m_q;
				state_d   = S_MUL_G2_WAIT;
			end
			S_MUL_G2_WAIT: if (gcd_done) state_d = S_MUL_DIV;
			S_MUL_M1: if (!mul_busy) state_d = S_MUL_M2;
			S_MUL_M2: if (!mul_busy) state_d = S_RED_START;
			S_DIV_M1: if (!mul_busy) state_d = S_DIV_M2;
			S_DIV_M2: if (!mul_busy) state_d = S_RED_START;
			S_RED_START: begin
				if (big_q || d_m_q == '0) state_d = S_OUT;
				else begin
					gcd_start = 1'b1;
					gcd_x     = n_m_q;
					gcd_y     = d_m_q;
					state_d   = S_RED_GCD_WAIT;
				end
			end
			S_RED_GCD_WAIT: if (gcd_done) state_d = S_RED_DIV;
			S_RED_DIV: begin
				if (sub_q == 2'd0 || (div_rsp.done && sub_q == 2'd1)) begin
					seq_div_req.start    = 1'b1;
					seq_div_req.dividend = (sub_q == 2'd0) ? n_m_q : d_m_q;
					seq_div_req.divisor  = g_q;
				end
				if (div_rsp.done && sub_q == 2'd2) state_d = S_RED_CHECK;
			end
			S_RED_CHECK: state_d = S_OUT;
			S_OUT: if (!out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// multiplier step counter: runs inside each multiply state
	logic in_mul;
	assign in_mul = (state_q == S_ADD_M1) || (state_q == S_ADD_M2) || (state_q == S_ADD_M3) ||
		(state_q == S_MUL_M1) || (state_q == S_MUL_M2) ||
		(state_q == S_DIV_M1) || (state_q == S_DIV_M2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mstep_q <= '0;
		end else if (in_mul) begin
			mstep_q <= (mstep_q == 2'd3) ? 2'd0 : mstep_q + 2'd1;
		end else begin
			mstep_q <= '0;
		end
	end

	// sub-step counter for division sequences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= '0;
		end else if (state_q != state_d) begin
			sub_q <= '0;
		end else if (seq_div_req.start) begin
			sub_q <= sub_q + 2'd1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		logic [MAG_W:0] d_an, d_ad, d_bn, d_bd;
		logic           prod_s;
		d_an = dec(an_raw_q);
		d_ad = dec(ad_raw_q);
		d_bn = dec(bn_raw_q);
		d_bd = dec(bd_raw_q);
		prod_s = 1'b0;
		if (state_q == S_IDLE && in_valid) begin
			op_q     <= op_t'(operation);
			an_raw_q <= a_num;
			ad_raw_q <= a_den;
			bn_raw_q <= b_num;
			bd_raw_q <= b_den;
		end
		if (in_mul) begin
			if (mstep_q == 2'd0) begin
				acc_q  <= acc_nx;
				mbig_q <= ovf_pp;
			end else if (mstep_q != 2'd3) begin
				acc_q  <= acc_nx;
				mbig_q <= mbig_q | (pp[63:32] != '0) | acc_nx[MAG_W];
			end
		end
		case (state_q)
			S_DEC: begin
				an_s_q <= d_an[MAG_W] && d_an[MAG_W-1:0] != '0;
				an_m_q <= d_an[MAG_W-1:0];
				ad_s_q <= d_ad[MAG_W];
				ad_m_q <= d_ad[MAG_W-1:0];
				bn_s_q <= (d_bn[MAG_W] ^ (op_q == OP_SUB)) && d_bn[MAG_W-1:0] != '0;
				bn_m_q <= d_bn[MAG_W-1:0];
				bd_s_q <= d_bd[MAG_W];
				bd_m_q <= d_bd[MAG_W-1:0];
				big_q  <= 1'b0;
				// normalize: load a directly
				n_s_q <= d_an[MAG_W] && d_an[MAG_W-1:0] != '0;
				n_m_q <= d_an[MAG_W-1:0];
				d_s_q <= d_ad[MAG_W];
				d_m_q <= d_ad[MAG_W-1:0];
				// add with equal denominators: numerator sum via sum path
				// multiply: t_s marks the cross-reduction pass, starts clear
				t_s_q <= (op_q != OP_MUL) && (d_bn[MAG_W] ^ (op_q == OP_SUB)) &&
					d_bn[MAG_W-1:0] != '0;
				t_m_q <= d_bn[MAG_W-1:0];
			end
			S_G1_WAIT: if (gcd_done) g_q <= gcd_res;
			S_ADD_SCALE: if (div_rsp.done) begin
				if (sub_q == 2'd1) t_m_q <= div_rsp.quot;
				else               g_q   <= div_rsp.quot;
			end
			S_ADD_M1: if (mstep_q == 2'd3) begin
				n_s_q <= (an_s_q ^ bd_s_q) && acc_q[MAG_W-1:0] != '0;
				n_m_q <= acc_q[MAG_W-1:0];
				big_q <= big_q | prod_big;
			end
			S_ADD_M2: if (mstep_q == 2'd3) begin
				t_s_q <= (bn_s_q ^ ad_s_q) && acc_q[MAG_W-1:0] != '0;
				t_m_q <= acc_q[MAG_W-1:0];
				big_q <= big_q | prod_big;
			end
			S_ADD_M3: if (mstep_q == 2'd3) begin
				// numerator sum and denominator product load at the same edge
				n_s_q <= sum_s && sum_m[MAG_W-1:0] != '0;
				n_m_q <= sum_m[MAG_W-1:0];
				d_s_q <= (ad_s_q ^ bd_s_q) && acc_q[MAG_W-1:0] != '0;
				d_m_q <= acc_q[MAG_W-1:0];
				big_q <= big_q | prod_big | sum_big;
			end
			S_ADD_SUM: begin
				n_s_q <= sum_s && sum_m[MAG_W-1:0] != '0;
				n_m_q <= sum_m[MAG_W-1:0];
				big_q <= sum_big;
			end
			S_MUL_DIV: begin
				if (div_rsp.done) begin
					if (!t_s_q) begin
						if (sub_q == 2'd1) an_m_q <= div_rsp.quot;
						else               bd_m_q <= div_rsp.quot;
					end else begin
						if (sub_q == 2'd1) ad_m_q <= div_rsp.quot;
						else               bn_m_q <= div_rsp.quot;
					end
				end
				if (state_d != state_q) t_s_q <= 1'b1;
			end
			S_MUL_G2_WAIT: if (gcd_done) g_q <= gcd_res;
			S_MUL_M1, S_DIV_M1: if (mstep_q == 2'd3) begin
				prod_s = (state_q == S_MUL_M1) ? (an_s_q ^ bn_s_q) : (an_s_q ^ bd_s_q);
				n_s_q <= prod_s && acc_q[MAG_W-1:0] != '0;
				n_m_q <= acc_q[MAG_W-1:0];
				big_q <= big_q | prod_big;
			end
			S_MUL_M2, S_DIV_M2: if (mstep_q == 2'd3) begin
				prod_s = (state_q == S_MUL_M2) ? (ad_s_q ^ bd_s_q) : (ad_s_q ^ bn_s_q);
				d_s_q <= prod_s && acc_q[MAG_W-1:0] != '0;
				d_m_q <= acc_q[MAG_W-1:0];
				big_q <= big_q | prod_big;
			end
			S_RED_START: begin
				if (d_s_q) begin
					n_s_q <= !n_s_q && n_m_q != '0;
					d_s_q <= 1'b0;
				end
			end
			S_RED_GCD_WAIT: if (gcd_done) g_q <= gcd_res;
			S_RED_DIV: if (div_rsp.done) begin
				if (sub_q == 2'd1) n_m_q <= div_rsp.quot;
				else               d_m_q <= div_rsp.quot;
			end
			default: ;
		endcase
	end

	// result assembly
	always_ff @(posedge clk) begin
		logic [MAG_W:0] d_an, d_ad;
		d_an = dec(an_raw_q);
		d_ad = dec(ad_raw_q);
		if (state_d == S_OUT && state_q != S_OUT) begin
			rn_q <= '0;
			rd_q <= '0;
			eq_q <= 1'b0;
			st_q <= ST_OK;
			case (op_q)
				OP_EQ: eq_q <= eq_hit;
				OP_NEG: begin
					if (d_ad[MAG_W-1:0] == '0) st_q <= ST_ZERO;
					else if (!fits(!d_an[MAG_W] && d_an[MAG_W-1:0] != '0, d_an[MAG_W-1:0]))
						st_q <= ST_OVF;
					else begin
						rn_q <= enc(!d_an[MAG_W], d_an[MAG_W-1:0]);
						rd_q <= ad_raw_q;
					end
				end
				OP_INV: begin
					if (d_ad[MAG_W-1:0] == '0 || d_an[MAG_W-1:0] == '0) st_q <= ST_ZERO;
					else begin
						rn_q <= ad_raw_q;
						rd_q <= an_raw_q;
					end
				end
				default: begin
					if (state_q == S_DEC || (!big_q && d_m_q == '0)) st_q <= ST_ZERO;
					else if (big_q) st_q <= ST_OVF;
					else if (!fits(n_s_q, n_m_q) || !fits(d_s_q, d_m_q)) st_q <= ST_OVF;
					else begin
						rn_q <= enc(n_s_q, n_m_q);
						rd_q <= enc(d_s_q, d_m_q);
					end
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign res_num   = rn_q;
	assign res_den   = rd_q;
	assign is_equal  = eq_q;
	assign status    = st_q;

`ifndef NO_ASSERTIONS
	// only one beat in flight: no accept while a result is pending
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while result pending");

	// equality flag only on equal operation
	a_eq_op: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_equal) |-> (op_q == OP_EQ))
		else $error("is_equal set for non-equal operation");

	// error status carries zero fields
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (res_num == '0 && res_den == '0))
		else $error("error result not zeroed");

	// a held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(res_num) && $stable(status)))
		else $error("result changed while stalled");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import rau_pkg::*;

	localparam int W          = 32;
	localparam int N_RANDOM   = 600;
	localparam int IDLE_PCT   = 11;
	localparam int QUIET_LO   = 250;   // no idling on either side in this beat window
	localparam int QUIET_HI   = 350;
	localparam int HOLD_AT    = 100;   // receiver holds off after this many results
	localparam int HOLD_LEN   = 2000;
	localparam int DRAIN_AT   = 400;   // sender waits for all results before this item
	localparam int TAIL_WAIT  = 50;
	localparam int DOG_LIMIT  = 100000;

	localparam logic [63:0] HALF = 64'd1 << (W - 1);
	localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

	typedef struct {
		bit          neg;
		logic [63:0] mag;
	} smag_t;

	typedef struct {
		op_t                    op;
		logic signed [W-1:0]    an, ad, bn, bd;
		bit                     drain;
	} frac_op_t;

	typedef struct {
		logic signed [W-1:0] num, den;
		logic                eq;
		status_t             st;
	} frac_res_t;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                in_valid = 0;
	logic                in_stall;
	logic [2:0]          operation = '0;
	logic signed [W-1:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
	logic                out_valid;
	logic                out_stall = 0;
	logic signed [W-1:0] res_num, res_den;
	logic                is_equal;
	logic [1:0]          status;

	frac_op_t  pending_ops[$];
	frac_res_t expected_res[$];
	int        errors = 0;
	int        beats_in = 0;
	int        beats_out = 0;
	int        hold_left = 0;
	bit        hold_done = 0;
	int        dog = 0;

	rational_arithmetic_unit #(.OPERAND_WIDTH(W)) DUT (
		.clk, .arst_n, .in_valid, .in_stall, .operation,
		.a_num, .a_den, .b_num, .b_den,
		.out_valid, .out_stall, .res_num, .res_den, .is_equal, .status
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------- signed-magnitude predictor ----------------
	function automatic smag_t mk(bit neg, logic [63:0] mag);
		smag_t r;
		r.mag = mag;
		r.neg = neg && (mag != 0);
		return r;
	endfunction

	function automatic smag_t from_raw(logic signed [W-1:0] raw);
		logic [63:0] v;
		v = {{(64-W){1'b0}}, raw};
		if (raw[W-1])
			return mk(1, 64'd0 - {{(64-W){raw[W-1]}}, raw});
		return mk(0, v);
	endfunction

	function automatic logic [W-1:0] to_raw(smag_t v);
		logic [63:0] t;
		t = v.neg ? (64'd0 - v.mag) : v.mag;
		return t[W-1:0];
	endfunction

	function automatic bit in_range(smag_t v);
		return v.neg ? (v.mag <= HALF) : (v.mag <= HALF - 1);
	endfunction

	function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic smag_t mag_mul(smag_t a, smag_t b, inout bit big);
		logic [127:0] p;
		p = a.mag * b.mag;
		if (p[127:64] != 0) begin
			big = 1;
			return mk(0, 0);
		end
		return mk(a.neg != b.neg, p[63:0]);
	endfunction

	function automatic smag_t mag_add(smag_t a, smag_t b, inout bit big);
		logic [64:0] s;
		if (a.neg == b.neg) begin
			s = a.mag + b.mag;
			if (s[64]) begin
				big = 1;
				return mk(0, 0);
			end
			return mk(a.neg, s[63:0]);
		end
		if (a.mag >= b.mag)
			return mk(a.neg, a.mag - b.mag);
		return mk(b.neg, b.mag - a.mag);
	endfunction

	function automatic smag_t flip(smag_t a);
		return mk(!a.neg, a.mag);
	endfunction

	function automatic smag_t scale_down(smag_t a, logic [63:0] g);
		return (g == 0) ? a : mk(a.neg, a.mag / g);
	endfunction

	function automatic frac_res_t pack_res(smag_t n, smag_t d, status_t st);
		frac_res_t r;
		r.num = (st == ST_OK) ? to_raw(n) : '0;
		r.den = (st == ST_OK) ? to_raw(d) : '0;
		r.eq  = 0;
		r.st  = st;
		return r;
	endfunction

	// reduce by gcd, force positive denominator, then range check
	function automatic frac_res_t reduce_frac(smag_t n, smag_t d, bit big, bit zero);
		logic [63:0] g;
		if (zero || (!big && d.mag == 0))
			return pack_res(n, d, ST_ZERO);
		if (big)
			return pack_res(n, d, ST_OVF);
		if (d.neg) begin
			n = flip(n);
			d = flip(d);
		end
		g = euclid(n.mag, d.mag);
		n = scale_down(n, g);
		d = scale_down(d, g);
		return pack_res(n, d, (in_range(n) && in_range(d)) ? ST_OK : ST_OVF);
	endfunction

	function automatic frac_res_t rational_result(frac_op_t it);
		smag_t an, ad, bn, bd, n, d, l, r, z;
		bit big;
		bit anyz;
		logic [63:0] g;
		frac_res_t res;
		an = from_raw(it.an);
		ad = from_raw(it.ad);
		bn = from_raw(it.bn);
		bd = from_raw(it.bd);
		z = mk(0, 0);
		big = 0;
		anyz = (ad.mag == 0) || (bd.mag == 0);
		case (it.op)
			OP_ADD, OP_SUB: begin
				if (it.op == OP_SUB)
					bn = flip(bn);
				if (anyz)
					return reduce_frac(z, z, 0, 1);
				if (ad.neg == bd.neg && ad.mag == bd.mag) begin
					n = mag_add(an, bn, big);
					d = ad;
				end else begin
					// scale by gcd of denominators
					g = euclid(ad.mag, bd.mag);
					l = scale_down(ad, g);
					r = scale_down(bd, g);
					n = mag_add(mag_mul(an, r, big), mag_mul(bn, l, big), big);
					d = mag_mul(ad, r, big);
				end
				return reduce_frac(n, d, big, 0);
			end
			OP_MUL: begin
				if (anyz)
					return reduce_frac(z, z, 0, 1);
				g = euclid(an.mag, bd.mag);
				an = scale_down(an, g);
				bd = scale_down(bd, g);
				g = euclid(ad.mag, bn.mag);
				ad = scale_down(ad, g);
				bn = scale_down(bn, g);
				n = mag_mul(an, bn, big);
				d = mag_mul(ad, bd, big);
				return reduce_frac(n, d, big, 0);
			end
			OP_DIV: begin
				if (anyz || bn.mag == 0)
					return reduce_frac(z, z, 0, 1);
				n = mag_mul(an, bd, big);
				d = mag_mul(ad, bn, big);
				return reduce_frac(n, d, big, 0);
			end
			OP_NEG: begin
				if (ad.mag == 0)
					return pack_res(an, ad, ST_ZERO);
				n = flip(an);
				return pack_res(n, ad, in_range(n) ? ST_OK : ST_OVF);
			end
			OP_INV: begin
				if (ad.mag == 0 || an.mag == 0)
					return pack_res(ad, an, ST_ZERO);
				return pack_res(ad, an, ST_OK);
			end
			OP_NORM:
				return reduce_frac(an, ad, 0, ad.mag == 0);
			default: begin
				res = pack_res(z, z, ST_OK);
				res.eq = (it.an == it.bn) && (it.ad == it.bd);
				return res;
			end
		endcase
	endfunction

	// ---------------- stimulus ----------------
	function automatic logic signed [W-1:0] rand_part(bit is_den);
		int sel;
		sel = $urandom_range(0, 19);
		if (is_den && sel == 0)
			return '0;
		case (sel % 10)
			0: return '0;
			1, 2, 3, 4: return $signed($urandom_range(0, 200)) - 100;
			5, 6: return $signed($urandom_range(0, 65535)) - 32768;
			7: return ($urandom_range(0, 1)) ? MINV : MAXV;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_op(op_t op, logic signed [W-1:0] an, ad, bn, bd);
		frac_op_t it;
		it.op = op;
		it.an = an;
		it.ad = ad;
		it.bn = bn;
		it.bd = bd;
		it.drain = 0;
		pending_ops.push_back(it);
	endtask

	initial begin
		frac_op_t it;
		// directed: each operation, extremes and the special cases
		add_op(OP_ADD, 1, 2, 1, 3);
		add_op(OP_ADD, 3, 4, -1, 4);
		add_op(OP_ADD, MAXV, 1, 1, 1);         // sum too wide
		add_op(OP_ADD, 1, 0, 1, 3);            // zero denominator
		add_op(OP_SUB, 5, -6, 1, 6);
		add_op(OP_SUB, MINV, 1, MAXV, 1);
		add_op(OP_MUL, MAXV, 3, MAXV, 7);      // product overflows
		add_op(OP_MUL, 6, 35, 14, -9);         // cross reduction
		add_op(OP_MUL, 2, 3, 4, 0);
		add_op(OP_DIV, 1, 2, 0, 5);            // divide by zero value
		add_op(OP_DIV, MINV, MINV, MINV, MINV);
		add_op(OP_DIV, -3, 7, 9, -14);
		add_op(OP_NEG, MINV, 1, 0, 0);         // negating most negative
		add_op(OP_NEG, 5, 0, 0, 0);
		add_op(OP_NEG, 7, -3, 0, 0);
		add_op(OP_INV, 0, 5, 0, 0);            // invert zero
		add_op(OP_INV, -4, 6, 0, 0);
		add_op(OP_INV, 4, 0, 0, 0);
		add_op(OP_NORM, 0, 0, 0, 0);           // zero over zero
		add_op(OP_NORM, 12, -18, 0, 0);
		add_op(OP_NORM, MINV, -1, 0, 0);       // positive result too big
		add_op(OP_NORM, 0, MINV, 0, 0);
		add_op(OP_EQ, 3, 5, 3, 5);
		add_op(OP_EQ, 3, 0, 3, 0);             // no denominator check
		add_op(OP_EQ, 1, 2, 2, 4);             // equal value, not equal fields
		for (int i = 0; i < N_RANDOM; i++) begin
			it.op = op_t'($urandom_range(0, 7));
			it.an = rand_part(0);
			it.ad = rand_part(1);
			it.bn = rand_part(0);
			it.bd = rand_part(1);
			if (it.op == OP_EQ && $urandom_range(0, 2) == 0) begin
				it.bn = it.an;
				it.bd = it.ad;
			end
			it.drain = 0;
			pending_ops.push_back(it);
		end
		pending_ops[DRAIN_AT].drain = 1;

		repeat (3) @(posedge clk);
		arst_n <= 1;
		while (pending_ops.size() != 0 || in_valid || expected_res.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------- driver ----------------
	always @(posedge clk or negedge arst_n) begin
		frac_op_t cur, nxt;
		bit quiet;
		if (!arst_n) begin
			in_valid <= 0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid) begin
				// beat taken at this edge
				cur.op = op_t'(operation);
				cur.an = a_num;
				cur.ad = a_den;
				cur.bn = b_num;
				cur.bd = b_den;
				expected_res.push_back(rational_result(cur));
				beats_in++;
			end
			quiet = (beats_in >= QUIET_LO && beats_in < QUIET_HI);
			if (pending_ops.size() != 0 &&
			    !(pending_ops[0].drain && expected_res.size() != 0) &&
			    (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
				nxt = pending_ops.pop_front();
				in_valid  <= 1;
				operation <= nxt.op;
				a_num     <= nxt.an;
				a_den     <= nxt.ad;
				b_num     <= nxt.bn;
				b_den     <= nxt.bd;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// ---------------- monitor / checker ----------------
	always @(posedge clk or negedge arst_n) begin
		frac_res_t e;
		bit quiet;
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				beats_out++;
				if (expected_res.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					e = expected_res.pop_front();
					if (res_num !== e.num) begin
						$error("res_num exp %0d got %0d", e.num, res_num);
						errors++;
					end
					if (res_den !== e.den) begin
						$error("res_den exp %0d got %0d", e.den, res_den);
						errors++;
					end
					if (is_equal !== e.eq) begin
						$error("is_equal exp %0d got %0d", e.eq, is_equal);
						errors++;
					end
					if (status !== e.st) begin
						$error("status exp %0d got %0d", e.st, status);
						errors++;
					end
				end
			end
			// one long hold-off so the input side backs up behind it
			if (!hold_done && beats_out >= HOLD_AT) begin
				hold_done = 1;
				hold_left = HOLD_LEN;
			end
			quiet = (beats_out >= QUIET_LO && beats_out < QUIET_HI);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1;
			end else begin
				out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// ---------------- watchdog ----------------
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			dog <= 0;
		else
			dog <= dog + 1;
		if (dog > DOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule
